// File: hw/rtl/joystick_radial_deadzone_unit_macros.svh
// Assertion macros for the radial deadzone unit.
// Used by the checker; no other dependencies.
`ifndef JOYSTICK_RADIAL_DEADZONE_UNIT_MACROS_SVH
`define JOYSTICK_RADIAL_DEADZONE_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define JRD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jrd assertion failed");

// condition must never hold
`define JRD_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("jrd assertion failed");

`endif

// File: hw/rtl/jrd_pkg.sv
// Shared constants for the radial deadzone unit.
// No dependencies.
`default_nettype none

package jrd_pkg;
   // output full scale of the rescaled stick
   localparam logic [14:0] FULL_SCALE = 15'd32767;
   // root pipeline: two result bits per stage, 16 bits of root
   localparam int SQRT_STAGES = 8;
   // divider: one quotient bit per stage, overflow test plus 17 bits
   localparam int DIV_STAGES = 18;
   // registers from accepted item to result strobe
   localparam int PIPE_LAT = 3 + SQRT_STAGES + 3 + DIV_STAGES + 1;
endpackage

`default_nettype wire

// File: hw/rtl/jrd_isqrt.sv
// Pipelined integer square root of a 32-bit value, two bits per stage.
// Depends on jrd_pkg.
`default_nettype none

module jrd_isqrt
   import jrd_pkg::*;
#(
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [31:0]       in_n,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [15:0]            out_root,
   output logic [SIDE_W-1:0]      out_side
);

   logic              v_ff    [SQRT_STAGES];
   logic [17:0]       rem_ff  [SQRT_STAGES];
   logic [15:0]       root_ff [SQRT_STAGES];
   logic [31:0]       n_ff    [SQRT_STAGES];
   logic [SIDE_W-1:0] side_ff [SQRT_STAGES];

   for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
      logic              p_v;
      logic [17:0]       p_rem;
      logic [15:0]       p_root;
      logic [31:0]       p_n;
      logic [SIDE_W-1:0] p_side;
      logic [17:0]       rem_in;
      logic [15:0]       root_in;
      logic [31:0]       n_in;

      if (s == 0) begin : g_first
         assign p_v    = in_valid;
         assign p_rem  = '0;
         assign p_root = '0;
         assign p_n    = in_n;
         assign p_side = in_side;
      end else begin : g_next
         assign p_v    = v_ff[s-1];
         assign p_rem  = rem_ff[s-1];
         assign p_root = root_ff[s-1];
         assign p_n    = n_ff[s-1];
         assign p_side = side_ff[s-1];
      end

      // two restoring root steps
      always_comb begin
         logic [19:0] t;
         logic [19:0] trial;
         rem_in  = p_rem;
         root_in = p_root;
         n_in    = p_n;
         for (int i = 0; i < 2; i++) begin
            t     = {rem_in, n_in[31:30]};
            trial = {2'b00, root_in, 2'b01};
            if (t >= trial) begin
               t       = t - trial;
               root_in = {root_in[14:0], 1'b1};
            end else begin
               root_in = {root_in[14:0], 1'b0};
            end
            rem_in = t[17:0];
            n_in   = {n_in[29:0], 2'b00};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else begin
            v_ff[s] <= p_v;
         end
         rem_ff[s]  <= rem_in;
         root_ff[s] <= root_in;
         n_ff[s]    <= n_in;
         side_ff[s] <= p_side;
      end
   end

   assign out_valid = v_ff[SQRT_STAGES-1];
   assign out_root  = root_ff[SQRT_STAGES-1];
   assign out_side  = side_ff[SQRT_STAGES-1];

endmodule

`default_nettype wire

// File: hw/rtl/jrd_div.sv
// Pipelined restoring divider, one quotient bit per stage, with an
// overflow flag for quotients of 2^17 and up. Depends on jrd_pkg.
`default_nettype none

module jrd_div
   import jrd_pkg::*;
#(
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [45:0]       in_num,
   input  wire logic [30:0]       in_den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [16:0]            out_quo,
   output logic                   out_ovf,
   output logic [SIDE_W-1:0]      out_side
);

   logic              v_ff    [DIV_STAGES];
   logic [45:0]       rem_ff  [DIV_STAGES];
   logic [30:0]       den_ff  [DIV_STAGES];
   logic [16:0]       quo_ff  [DIV_STAGES];
   logic              ovf_ff  [DIV_STAGES];
   logic [SIDE_W-1:0] side_ff [DIV_STAGES];

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
      localparam int K = DIV_STAGES - 1 - j;
      logic              p_v;
      logic [45:0]       p_rem;
      logic [30:0]       p_den;
      logic [16:0]       p_quo;
      logic              p_ovf;
      logic [SIDE_W-1:0] p_side;
      logic [47:0]       shifted;
      logic              ge;
      logic [45:0]       rem_in;
      logic [16:0]       quo_in;
      logic              ovf_in;

      if (j == 0) begin : g_first
         assign p_v    = in_valid;
         assign p_rem  = in_num;
         assign p_den  = in_den;
         assign p_quo  = '0;
         assign p_ovf  = 1'b0;
         assign p_side = in_side;
      end else begin : g_next
         assign p_v    = v_ff[j-1];
         assign p_rem  = rem_ff[j-1];
         assign p_den  = den_ff[j-1];
         assign p_quo  = quo_ff[j-1];
         assign p_ovf  = ovf_ff[j-1];
         assign p_side = side_ff[j-1];
      end

      assign shifted = {17'd0, p_den} << K;
      assign ge      = {2'b00, p_rem} >= shifted;

      // first stage only tests for overflow; the rest subtract
      if (j == 0) begin : g_ovf
         assign rem_in = p_rem;
         assign quo_in = p_quo;
         assign ovf_in = ge;
      end else begin : g_sub
         logic [47:0] diff;
         assign diff   = {2'b00, p_rem} - shifted;
         assign rem_in = ge ? diff[45:0] : p_rem;
         assign quo_in = ge ? (p_quo | (17'd1 << K)) : p_quo;
         assign ovf_in = p_ovf;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else begin
            v_ff[j] <= p_v;
         end
         rem_ff[j]  <= rem_in;
         den_ff[j]  <= p_den;
         quo_ff[j]  <= quo_in;
         ovf_ff[j]  <= ovf_in;
         side_ff[j] <= p_side;
      end
   end

   assign out_valid = v_ff[DIV_STAGES-1];
   assign out_quo   = quo_ff[DIV_STAGES-1];
   assign out_ovf   = ovf_ff[DIV_STAGES-1];
   assign out_side  = side_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

// File: hw/rtl/joystick_radial_deadzone_unit.sv
// Top level of the scaled radial deadzone unit.
// Depends on jrd_pkg, jrd_isqrt and jrd_div.
//
//  channel  ports                         handshake
//  request  req_start, req_stick_x/y      taken when req_start and !busy
//  result   rsp_valid, rsp_out_x/y, flag  one-cycle strobe, no back-pressure
//  config   csr_we, csr_wdata             written on csr_we
//
// One item per cycle; the pipeline runs through the 8-stage square root
// and the 18-stage divider. busy stays low.
// Synchronous reset clears the valid bits and the deadzone radius.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module joystick_radial_deadzone_unit
   import jrd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_start,
   output logic                    busy,
   input  wire logic signed [15:0] req_stick_x,
   input  wire logic signed [15:0] req_stick_y,
   input  wire logic               csr_we,
   input  wire logic [14:0]        csr_wdata,
   output logic                    rsp_valid,
   output logic signed [15:0]      rsp_out_x,
   output logic signed [15:0]      rsp_out_y,
   output logic                    rsp_in_deadzone
);

   // saturate a quotient magnitude to a signed 16-bit result
   function automatic logic [15:0] sat_axis(input logic [16:0] q, input logic ovf,
                                            input logic neg);
      logic [16:0] nq;
      nq = ~q + 17'd1;
      if (neg) begin
         sat_axis = (ovf || q > 17'd32768) ? 16'h8000 : nq[15:0];
      end else begin
         sat_axis = (ovf || q > 17'd32767) ? 16'h7fff : q[15:0];
      end
   endfunction

   assign busy = 1'b0;

   // deadzone radius register, clamped below full scale
   logic [14:0] dz_ff;
   logic [14:0] dz_eff;
   always_ff @(posedge clock) begin
      if (reset) begin
         dz_ff <= '0;
      end else if (csr_we) begin
         dz_ff <= csr_wdata;
      end
   end
   assign dz_eff = (dz_ff >= FULL_SCALE) ? (FULL_SCALE - 15'd1) : dz_ff;

   // stage 1: absolute values and signs
   logic        s1_v_ff;
   logic [16:0] s1_ax_ff, s1_ay_ff;
   logic        s1_sx_ff, s1_sy_ff;
   logic [16:0] ax_in, ay_in;
   assign ax_in = req_stick_x[15] ? (~{1'b1, req_stick_x} + 17'd1) : {1'b0, req_stick_x};
   assign ay_in = req_stick_y[15] ? (~{1'b1, req_stick_y} + 17'd1) : {1'b0, req_stick_y};

   // stage 2: squares
   logic        s2_v_ff;
   logic [16:0] s2_ax_ff, s2_ay_ff;
   logic        s2_sx_ff, s2_sy_ff;
   logic [30:0] s2_qx_ff, s2_qy_ff;
   logic [33:0] qx_full, qy_full;
   assign qx_full = 34'(s1_ax_ff) * 34'(s1_ax_ff);
   assign qy_full = 34'(s1_ay_ff) * 34'(s1_ay_ff);

   // stage 3: sum of squares
   logic        s3_v_ff;
   logic [35:0] s3_side_ff;
   logic [31:0] s3_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= req_start & ~busy;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
      s1_ax_ff   <= ax_in;
      s1_ay_ff   <= ay_in;
      s1_sx_ff   <= req_stick_x[15];
      s1_sy_ff   <= req_stick_y[15];
      s2_ax_ff   <= s1_ax_ff;
      s2_ay_ff   <= s1_ay_ff;
      s2_sx_ff   <= s1_sx_ff;
      s2_sy_ff   <= s1_sy_ff;
      s2_qx_ff   <= qx_full[30:0];
      s2_qy_ff   <= qy_full[30:0];
      s3_sq_ff   <= {1'b0, s2_qx_ff} + {1'b0, s2_qy_ff};
      s3_side_ff <= {s2_sx_ff, s2_sy_ff, s2_ax_ff, s2_ay_ff};
   end

   // magnitude
   logic        rt_v;
   logic [15:0] rt_mag;
   logic [35:0] rt_side;
   jrd_isqrt #(.SIDE_W(36)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_v_ff),
      .in_n      (s3_sq_ff),
      .in_side   (s3_side_ff),
      .out_valid (rt_v),
      .out_root  (rt_mag),
      .out_side  (rt_side)
   );

   // post stage: deadzone test and scale terms
   logic        p_v_ff, p_dead_ff, p_sx_ff, p_sy_ff;
   logic [16:0] p_ax_ff, p_ay_ff;
   logic [15:0] p_mag_ff, p_diff_ff;
   logic [14:0] p_dena_ff;

   // multiply 1: axis times excess, and denominator
   logic        m1_v_ff, m1_dead_ff, m1_sx_ff, m1_sy_ff;
   logic [30:0] m1_px_ff, m1_py_ff, m1_den_ff;
   logic [32:0] px_full, py_full;
   logic [30:0] den_full;
   assign px_full  = 33'(p_ax_ff) * 33'(p_diff_ff);
   assign py_full  = 33'(p_ay_ff) * 33'(p_diff_ff);
   assign den_full = 31'(p_dena_ff) * 31'(p_mag_ff);

   // multiply 2: times full scale
   logic        m2_v_ff, m2_dead_ff, m2_sx_ff, m2_sy_ff;
   logic [45:0] m2_nx_ff, m2_ny_ff;
   logic [30:0] m2_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff  <= 1'b0;
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
      end else begin
         p_v_ff  <= rt_v;
         m1_v_ff <= p_v_ff;
         m2_v_ff <= m1_v_ff;
      end
      p_dead_ff  <= (rt_mag == 16'd0) || (rt_mag < {1'b0, dz_eff});
      p_sx_ff    <= rt_side[35];
      p_sy_ff    <= rt_side[34];
      p_ax_ff    <= rt_side[33:17];
      p_ay_ff    <= rt_side[16:0];
      p_mag_ff   <= rt_mag;
      p_diff_ff  <= rt_mag - {1'b0, dz_eff};
      p_dena_ff  <= FULL_SCALE - dz_eff;
      m1_dead_ff <= p_dead_ff;
      m1_sx_ff   <= p_sx_ff;
      m1_sy_ff   <= p_sy_ff;
      m1_px_ff   <= px_full[30:0];
      m1_py_ff   <= py_full[30:0];
      m1_den_ff  <= den_full;
      m2_dead_ff <= m1_dead_ff;
      m2_sx_ff   <= m1_sx_ff;
      m2_sy_ff   <= m1_sy_ff;
      m2_nx_ff   <= 46'(m1_px_ff) * 46'(FULL_SCALE);
      m2_ny_ff   <= 46'(m1_py_ff) * 46'(FULL_SCALE);
      m2_den_ff  <= m1_den_ff;
   end

   // per-axis dividers
   logic        dx_v, dy_v, dx_ovf, dy_ovf;
   logic [16:0] dx_q, dy_q;
   logic [1:0]  dx_side;
   logic        dy_side;
   jrd_div #(.SIDE_W(2)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m2_v_ff),
      .in_num    (m2_nx_ff),
      .in_den    (m2_den_ff),
      .in_side   ({m2_dead_ff, m2_sx_ff}),
      .out_valid (dx_v),
      .out_quo   (dx_q),
      .out_ovf   (dx_ovf),
      .out_side  (dx_side)
   );
   jrd_div #(.SIDE_W(1)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m2_v_ff),
      .in_num    (m2_ny_ff),
      .in_den    (m2_den_ff),
      .in_side   (m2_sy_ff),
      .out_valid (dy_v),
      .out_quo   (dy_q),
      .out_ovf   (dy_ovf),
      .out_side  (dy_side)
   );

   // output register: saturate, force zero in the deadzone
   logic        o_v_ff, o_dz_ff;
   logic [15:0] o_x_ff, o_y_ff;
   logic        o_dead;
   assign o_dead = dx_side[1];
   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else begin
         o_v_ff <= dx_v & dy_v;
      end
      o_dz_ff <= dx_v & o_dead;
      o_x_ff  <= (o_dead || !dx_v) ? 16'd0 : sat_axis(dx_q, dx_ovf, dx_side[0]);
      o_y_ff  <= (o_dead || !dx_v) ? 16'd0 : sat_axis(dy_q, dy_ovf, dy_side);
   end

   assign rsp_valid       = o_v_ff;
   assign rsp_out_x       = o_x_ff;
   assign rsp_out_y       = o_y_ff;
   assign rsp_in_deadzone = o_dz_ff;

endmodule

`default_nettype wire

// File: hw/rtl/jrd_checker.sv
// Port-level checker for the radial deadzone unit, bound to the top level.
// Depends on jrd_pkg and the assertion macro header.
`default_nettype none
`include "joystick_radial_deadzone_unit_macros.svh"

module jrd_checker
   import jrd_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [15:0] rsp_out_x,
   input wire logic [15:0] rsp_out_y,
   input wire logic        rsp_in_deadzone
);

   // the unit never refuses an item
   `JRD_ASSERT_NEVER(a_never_busy, clock, reset, busy)
   // every result stems from an item taken a fixed latency earlier
   `JRD_ASSERT_IMP(a_fixed_latency, clock, reset, rsp_valid, $past(req_start, PIPE_LAT))
   // deadzone results are zero and only come with the strobe
   `JRD_ASSERT_IMP(a_dz_zero, clock, reset, rsp_in_deadzone, rsp_valid && rsp_out_x == 16'd0 && rsp_out_y == 16'd0)

endmodule

bind joystick_radial_deadzone_unit jrd_checker u_jrd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_start       (req_start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_out_x       (rsp_out_x),
   .rsp_out_y       (rsp_out_y),
   .rsp_in_deadzone (rsp_in_deadzone)
);

`default_nettype wire

// File: tb/tb_joystick_radial_deadzone_unit.sv
// Testbench for joystick_radial_deadzone_unit: drives stick samples, predicts the
// rescaled output in bit-exact integer math and checks every result strobe.
// Depends on jrd_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module tb_joystick_radial_deadzone_unit;
   import jrd_pkg::*;

   typedef struct packed {
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic               in_dz;
   } stick_result_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_start = 1'b0;
   logic signed [15:0] req_stick_x = '0;
   logic signed [15:0] req_stick_y = '0;
   logic               csr_we = 1'b0;
   logic [14:0]        csr_wdata = '0;
   wire                busy;
   wire                rsp_valid;
   wire signed [15:0]  rsp_out_x;
   wire signed [15:0]  rsp_out_y;
   wire                rsp_in_deadzone;

   // predictor's copy of the radius register
   logic [14:0]   radius_shadow = '0;
   stick_result_t pending_q[$];
   int            mismatch_cnt = 0;
   int            idle_cycles = 0;
   localparam int WATCHDOG_LIMIT = 4000;

   joystick_radial_deadzone_unit dut (
      .clock(clock), .reset(reset), .req_start(req_start), .busy(busy),
      .req_stick_x(req_stick_x), .req_stick_y(req_stick_y),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_in_deadzone(rsp_in_deadzone)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // floor of the square root, bit by bit
   function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // rescale one axis, truncate toward zero, saturate
   function automatic logic signed [15:0] rescale_axis(logic signed [15:0] v,
         longint unsigned mag, longint unsigned dz);
      longint unsigned a, q;
      a = (v < 0) ? longint'(-int'(v)) : longint'(v);
      q = (a * (mag - dz) * 32767) / ((64'd32767 - dz) * mag);
      if (v < 0) return (q > 32768) ? -16'sd32768 : 16'(-longint'(q));
      return (q > 32767) ? 16'sd32767 : 16'(q);
   endfunction

   function automatic stick_result_t predict_deadzone(logic signed [15:0] x,
         logic signed [15:0] y);
      stick_result_t r;
      longint sx, sy;
      longint unsigned mag, dz;
      sx = x;
      sy = y;
      mag = floor_sqrt(longint'(sx * sx + sy * sy));
      dz = radius_shadow;
      if (dz >= 32767) dz = 32766;
      if (mag == 0 || mag < dz) begin
         r = '{16'sd0, 16'sd0, 1'b1};
      end else begin
         r.out_x = rescale_axis(x, mag, dz);
         r.out_y = rescale_axis(y, mag, dz);
         r.in_dz = 1'b0;
      end
      return r;
   endfunction

   // result checker and watchdog
   always @(posedge clock) begin
      stick_result_t e;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_q.size() == 0) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10) $display("unexpected result %0d %0d %0d",
                  rsp_out_x, rsp_out_y, rsp_in_deadzone);
            end else begin
               e = pending_q.pop_front();
               if (e.out_x !== rsp_out_x || e.out_y !== rsp_out_y ||
                     e.in_dz !== rsp_in_deadzone) begin
                  mismatch_cnt++;
                  if (mismatch_cnt <= 10)
                     $display("mismatch: exp %0d %0d %0d got %0d %0d %0d",
                        e.out_x, e.out_y, e.in_dz, rsp_out_x, rsp_out_y,
                        rsp_in_deadzone);
               end
            end
         end
         if (rsp_valid || (req_start && !busy)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_joystick_radial_deadzone_unit: errors");
            $finish;
         end
      end
   end

   int burst_left = 0;

   // send one item; bursts with random gaps between them, start held inside a burst
   task automatic send_item(logic signed [15:0] x, logic signed [15:0] y);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
         if (gap != 0) begin
            req_start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_start <= 1'b1;
      req_stick_x <= x;
      req_stick_y <= y;
      do @(posedge clock); while (busy);
      pending_q.push_back(predict_deadzone(x, y));
   endtask

   // write the radius with the pipeline drained
   task automatic write_radius(logic [14:0] val);
      req_start <= 1'b0;
      burst_left = 0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 4) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      radius_shadow = val;
   endtask

   // extremes of both axes, the zero vector, small vectors and a mixed-sign sample
   task automatic test_directed(logic [14:0] radius);
      write_radius(radius);
      send_item(0, 0);
      send_item(16'sh7fff, 0);
      send_item(-16'sd32768, 0);
      send_item(0, -16'sd32768);
      send_item(16'sh7fff, 16'sh7fff);
      send_item(-16'sd32768, -16'sd32768);
      send_item(-16'sd32768, 16'sh7fff);
      send_item(1, 0);
      send_item(-1, -1);
      send_item(16'sh5555, -16'sh2aab);
   endtask

   // samples near the deadzone edge and full range noise
   task automatic test_random(int count);
      int   k, mag;
      logic signed [15:0] x, y;
      for (k = 0; k < count; k++) begin
         if ($urandom_range(0, 2) == 0) begin
            mag = int'(radius_shadow) + $urandom_range(0, 6) - 3;
            if (mag < 0) mag = 0;
            x = 16'(mag);
            y = 16'($urandom_range(0, 3) - 1);
            if ($urandom_range(0, 1)) begin
               x = -x;
            end
            if ($urandom_range(0, 1)) begin
               {x, y} = {y, x};
            end
         end else begin
            x = 16'($urandom);
            y = 16'($urandom);
         end
         send_item(x, y);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed(15'd0);
      test_directed(15'd32767);
      test_directed(15'd32766);
      test_directed(15'd8000);
      write_radius(15'd0);
      test_random(200);
      write_radius(15'($urandom_range(1, 32766)));
      test_random(200);
      write_radius(15'($urandom_range(100, 3000)));
      test_random(250);
      write_radius(15'd32767);
      test_random(60);
      write_radius(15'h2aaa);
      test_random(60);
      req_start <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 4) @(posedge clock);
      if (mismatch_cnt == 0 && pending_q.size() == 0)
         $display("tb_joystick_radial_deadzone_unit: clean");
      else
         $display("tb_joystick_radial_deadzone_unit: errors");
      $finish;
   end
endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/jrd_pkg.sv
hw/rtl/jrd_isqrt.sv
hw/rtl/jrd_div.sv
hw/rtl/joystick_radial_deadzone_unit.sv
hw/rtl/jrd_checker.sv
tb/tb_joystick_radial_deadzone_unit.sv
